>>> src/deq_pkg.sv
// shared types, codes and sizes for the double-ended queue
package deq_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int MODE_W = 3;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 5;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int ASEL_W = 3;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_PUSH_TAIL = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_HEAD = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_HEAD  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_TAIL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_OVERWRITE = 3'd5;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

    // ring address select
    localparam logic [ASEL_W-1:0] ASEL_HEAD    = 3'd0;
    localparam logic [ASEL_W-1:0] ASEL_HEAD_M1 = 3'd1;
    localparam logic [ASEL_W-1:0] ASEL_TAIL    = 3'd2;
    localparam logic [ASEL_W-1:0] ASEL_LAST    = 3'd3;
    localparam logic [ASEL_W-1:0] ASEL_POS     = 3'd4;
    localparam logic [ASEL_W-1:0] ASEL_IDX     = 3'd5;
    localparam logic [ASEL_W-1:0] ASEL_IDX_M1  = 3'd6;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [POS_W-1:0]  position;
        logic [VAL_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  popped_value;
        logic [LEN_W-1:0]  length;
    } rsp_t;

    typedef struct packed {
        logic              load_cmd;
        logic              ram_we;
        logic              ram_re;
        logic [ASEL_W-1:0] asel;
        logic              wsel_shift;
        logic              head_inc;
        logic              head_dec;
        logic              count_inc;
        logic              count_dec;
        logic              idx_load;
        logic              idx_dec;
        logic              load_rsp;
        logic [STAT_W-1:0] rsp_status;
        logic              rsp_pop;
    } ctrl_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              full;
        logic              empty;
        logic              pos_gt_count;
        logic              pos_ge_count;
        logic              pos_eq_count;
        logic              last_shift;
        logic              rsp_busy;
    } stat_t;

endpackage

>>> src/deq_ram.sv
// generic single-write, single-read ram with registered read data
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/deq_dp.sv
// datapath: ring storage, head and count registers, address generation, result register
module deq_dp (
    input  logic           clk,
    input  logic           rst_n,
    input  deq_pkg::cmd_t  cmd,
    input  deq_pkg::ctrl_t ctrl,
    output deq_pkg::stat_t stat,
    input  logic           rsp_stall,
    output logic           rsp_valid,
    output deq_pkg::rsp_t  rsp
);

    localparam int DEPTH  = deq_pkg::DEPTH;
    localparam int DW     = deq_pkg::DATA_WIDTH;
    localparam int ADDR_W = deq_pkg::ADDR_W;
    localparam int CNT_W  = deq_pkg::CNT_W;
    localparam int CMP_W  = deq_pkg::CMP_W;
    localparam int SUM_W  = CMP_W + 1;
    localparam int VAL_W  = deq_pkg::VAL_W;
    localparam int LEN_W  = deq_pkg::LEN_W;

    logic [deq_pkg::MODE_W-1:0] mode_reg;
    logic [deq_pkg::POS_W-1:0]  pos_reg;
    logic [DW-1:0]              value_reg;
    logic [ADDR_W-1:0]          head_reg, head_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    deq_pkg::rsp_t              rsp_reg, rsp_next;
    logic                       rsp_valid_reg, rsp_valid_next;

    logic [CMP_W-1:0]  pos_ext, cnt_ext, idx_ext;
    logic [ADDR_W-1:0] head_m1, head_p1;
    logic [ADDR_W-1:0] ram_addr;
    logic [DW-1:0]     ram_wdata, ram_rdata;

    // ring slot of an offset from the head; offset is always below DEPTH
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] head,
                                                   input logic [CMP_W-1:0]  off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH))
        begin
            sum = sum - SUM_W'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    assign pos_ext = CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(count_reg);
    assign idx_ext = CMP_W'(idx_reg);

    assign head_m1 = (head_reg == '0) ? ADDR_W'(DEPTH - 1) : head_reg - ADDR_W'(1);
    assign head_p1 = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + ADDR_W'(1);

    always_comb
    begin
        case (ctrl.asel)
            deq_pkg::ASEL_HEAD:    ram_addr = head_reg;
            deq_pkg::ASEL_HEAD_M1: ram_addr = head_m1;
            deq_pkg::ASEL_TAIL:    ram_addr = slot_of(head_reg, cnt_ext);
            deq_pkg::ASEL_LAST:    ram_addr = slot_of(head_reg, cnt_ext - CMP_W'(1));
            deq_pkg::ASEL_POS:     ram_addr = slot_of(head_reg, pos_ext);
            deq_pkg::ASEL_IDX:     ram_addr = slot_of(head_reg, idx_ext);
            deq_pkg::ASEL_IDX_M1:  ram_addr = slot_of(head_reg, idx_ext - CMP_W'(1));
            default:               ram_addr = head_reg;
        endcase
    end

    // shift steps move the word just read one place back
    assign ram_wdata = ctrl.wsel_shift ? ram_rdata : value_reg;

    deq_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .re    (ctrl.ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        stat.mode         = mode_reg;
        stat.full         = (count_reg == CNT_W'(DEPTH));
        stat.empty        = (count_reg == '0);
        stat.pos_gt_count = (pos_ext > cnt_ext);
        stat.pos_ge_count = (pos_ext >= cnt_ext);
        stat.pos_eq_count = (pos_ext == cnt_ext);
        stat.last_shift   = (idx_ext == pos_ext + CMP_W'(1));
        stat.rsp_busy     = rsp_valid_reg && rsp_stall;
    end

    always_comb
    begin
        head_next = head_reg;
        if (ctrl.head_inc)
        begin
            head_next = head_p1;
        end
        else if (ctrl.head_dec)
        begin
            head_next = head_m1;
        end

        count_next = count_reg;
        if (ctrl.count_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.count_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        idx_next = idx_reg;
        if (ctrl.idx_load)
        begin
            idx_next = count_reg;
        end
        else if (ctrl.idx_dec)
        begin
            idx_next = idx_reg - CNT_W'(1);
        end

        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (ctrl.load_rsp)
        begin
            rsp_next.status       = ctrl.rsp_status;
            rsp_next.popped_value = ctrl.rsp_pop ? VAL_W'(ram_rdata) : '0;
            rsp_next.length       = LEN_W'(count_reg);
            rsp_valid_next        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_cmd)
        begin
            mode_reg  <= cmd.mode;
            pos_reg   <= cmd.position;
            value_reg <= DW'(cmd.value);
        end
        idx_reg <= idx_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("count above depth");

    a_no_rsp_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_rsp |-> !(rsp_valid_reg && rsp_stall))
        else $error("result loaded over a stalled beat");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.status != deq_pkg::ST_OK) |-> rsp_reg.popped_value == '0)
        else $error("failed operation returned data");

    a_inc_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.count_inc |-> (count_reg != CNT_W'(DEPTH) && !ctrl.count_dec))
        else $error("count grown past full");

    a_dec_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.count_dec |-> count_reg != '0)
        else $error("count shrunk below empty");

endmodule

>>> src/deq_ctrl.sv
// controller: sequences each operation and the insert shift loop
module deq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_stall,
    input  deq_pkg::stat_t stat,
    output deq_pkg::ctrl_t ctrl
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SHRD  = 3'd2;
    localparam logic [2:0] S_SHWR  = 3'd3;
    localparam logic [2:0] S_INSWR = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                 state_reg, state_next;
    logic [deq_pkg::STAT_W-1:0] status_reg, status_next;
    logic                       pop_reg, pop_next;

    always_comb
    begin
        ctrl            = '0;
        ctrl.asel       = deq_pkg::ASEL_HEAD;
        ctrl.rsp_status = status_reg;
        ctrl.rsp_pop    = pop_reg;
        state_next      = state_reg;
        status_next     = status_reg;
        pop_next        = pop_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctrl.load_cmd = 1'b1;
                    state_next    = S_EXEC;
                end
            end

            S_EXEC:
            begin
                status_next = deq_pkg::ST_OK;
                pop_next    = 1'b0;
                state_next  = S_DONE;
                case (stat.mode)
                    deq_pkg::MODE_PUSH_TAIL:
                    begin
                        if (stat.full)
                        begin
                            status_next = deq_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctrl.ram_we    = 1'b1;
                            ctrl.asel      = deq_pkg::ASEL_TAIL;
                            ctrl.count_inc = 1'b1;
                        end
                    end
                    deq_pkg::MODE_PUSH_HEAD:
                    begin
                        if (stat.full)
                        begin
                            status_next = deq_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctrl.ram_we    = 1'b1;
                            ctrl.asel      = deq_pkg::ASEL_HEAD_M1;
                            ctrl.head_dec  = 1'b1;
                            ctrl.count_inc = 1'b1;
                        end
                    end
                    deq_pkg::MODE_POP_HEAD:
                    begin
                        if (stat.empty)
                        begin
                            status_next = deq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ctrl.ram_re    = 1'b1;
                            ctrl.asel      = deq_pkg::ASEL_HEAD;
                            ctrl.head_inc  = 1'b1;
                            ctrl.count_dec = 1'b1;
                            pop_next       = 1'b1;
                        end
                    end
                    deq_pkg::MODE_POP_TAIL:
                    begin
                        if (stat.empty)
                        begin
                            status_next = deq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ctrl.ram_re    = 1'b1;
                            ctrl.asel      = deq_pkg::ASEL_LAST;
                            ctrl.count_dec = 1'b1;
                            pop_next       = 1'b1;
                        end
                    end
                    deq_pkg::MODE_INSERT:
                    begin
                        // position check goes ahead of the full check
                        if (stat.pos_gt_count)
                        begin
                            status_next = deq_pkg::ST_BADPOS;
                        end
                        else if (stat.full)
                        begin
                            status_next = deq_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctrl.idx_load = 1'b1;
                            state_next    = stat.pos_eq_count ? S_INSWR : S_SHRD;
                        end
                    end
                    deq_pkg::MODE_OVERWRITE:
                    begin
                        if (stat.pos_ge_count)
                        begin
                            status_next = deq_pkg::ST_BADPOS;
                        end
                        else
                        begin
                            ctrl.ram_we = 1'b1;
                            ctrl.asel   = deq_pkg::ASEL_POS;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_SHRD:
            begin
                ctrl.ram_re = 1'b1;
                ctrl.asel   = deq_pkg::ASEL_IDX_M1;
                state_next  = S_SHWR;
            end

            S_SHWR:
            begin
                ctrl.ram_we     = 1'b1;
                ctrl.asel       = deq_pkg::ASEL_IDX;
                ctrl.wsel_shift = 1'b1;
                ctrl.idx_dec    = 1'b1;
                state_next      = stat.last_shift ? S_INSWR : S_SHRD;
            end

            S_INSWR:
            begin
                ctrl.ram_we    = 1'b1;
                ctrl.asel      = deq_pkg::ASEL_POS;
                ctrl.count_inc = 1'b1;
                state_next     = S_DONE;
            end

            S_DONE:
            begin
                // hold until the result register is free
                if (!stat.rsp_busy)
                begin
                    ctrl.load_rsp = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= deq_pkg::ST_OK;
            pop_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            pop_reg    <= pop_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);

endmodule

>>> src/double_ended_queue.sv
// top level of the bounded double-ended queue
//
//   channel  dir  handshake              payload
//   cmd      in   cmd_valid / cmd_stall  deq_pkg::cmd_t (mode, position, value)
//   rsp      out  rsp_valid / rsp_stall  deq_pkg::rsp_t (status, popped_value, length)
//
// push, pop, overwrite and every rejected operation go through these steps:
// accept, execute against the ring ram, load the result register.
// insert also moves the entries from position on one place toward the tail; each
// entry moved is one ram read and one ram write over the single ram port pair.
// reset clears head, count and control; ring contents are undefined until written.
// a stalled result holds in its register while the next command is accepted;
// that command then waits at its last step until the register frees.
module double_ended_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  deq_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output deq_pkg::rsp_t rsp
);

    deq_pkg::ctrl_t ctrl;
    deq_pkg::stat_t stat;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    deq_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctrl      (ctrl),
        .stat      (stat),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule
